// ----- rtl/pdv_pkg.sv -----
`timescale 1ns / 1ps

package pdv_pkg;

    localparam int CFG_W = 12;
    localparam logic [CFG_W-1:0] CAP_RESET = 12'd2048;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] DEL_CHAR   = 8'h7f;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_HIGH   = 2'd1,
        PH_LOW    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MALFORMED = 3'd1,
        ST_NULL      = 3'd2,
        ST_CONTROL   = 3'd3,
        ST_TOO_LONG  = 3'd4
    } status_t;

    // per-path decoder state, minus the decoded byte count
    typedef struct packed {
        phase_t     phase;
        logic [3:0] high_digit;
        logic       failed;
    } path_state_t;

    typedef struct packed {
        logic       has_result;
        logic [7:0] out_byte;
        logic       out_byte_valid;
        status_t    status;
        logic       out_end;
    } result_t;

endpackage

// ----- rtl/pdv_if.sv -----
`timescale 1ns / 1ps

interface pdv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pdv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_byte_valid;
    logic [2:0] status;
    logic       out_end;

    modport source (output valid, output out_byte, output out_byte_valid, output status,
                    output out_end, input ready);
    modport sink   (input valid, input out_byte, input out_byte_valid, input status,
                    input out_end, output ready);
endinterface

interface pdv_cfg_if;
    logic        valid;
    logic        ready;
    logic [11:0] out_capacity;

    modport source (output valid, output out_capacity, input ready);
    modport sink   (input valid, input out_capacity, output ready);
endinterface

// ----- rtl/pdv_step.sv -----
`timescale 1ns / 1ps

module pdv_step
    import pdv_pkg::*;
#(
    parameter int CNT_W = 11
)
(
    input  path_state_t      state,
    input  logic [CNT_W-1:0] count,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic [CFG_W-1:0] cap,
    output path_state_t      state_next,
    output logic [CNT_W-1:0] count_next,
    output result_t          result
);

    function automatic logic [4:0] nibble_of(input logic [7:0] b);
        logic [4:0] r;
        begin
            r = 5'h10;
            if (b >= 8'h30 && b <= 8'h39)
            begin
                r = {1'b0, 4'(b - 8'h30)};
            end
            else if (b >= 8'h61 && b <= 8'h66)
            begin
                r = {1'b0, 4'(b - 8'h57)};
            end
            else if (b >= 8'h41 && b <= 8'h46)
            begin
                r = {1'b0, 4'(b - 8'h37)};
            end
            return r;
        end
    endfunction

    localparam path_state_t CLEAR_STATE = '{phase: PH_NORMAL, high_digit: 4'd0, failed: 1'b0};

    logic [4:0]     nib;
    logic           nib_bad;
    logic [7:0]     emit_byte;
    logic [CFG_W:0] cnt_inc;
    logic           full;
    logic           emit_fail;
    status_t        emit_status;

    assign nib       = nibble_of(in_byte);
    assign nib_bad   = nib[4];
    assign emit_byte = (state.phase == PH_NORMAL) ? in_byte : {state.high_digit, nib[3:0]};
    assign cnt_inc   = (CFG_W + 1)'(count) + 1'b1;
    assign full      = cnt_inc >= {1'b0, cap};

    // checks on a decoded byte, in priority order
    always_comb
    begin
        emit_fail   = 1'b1;
        emit_status = ST_OK;
        if (emit_byte == 8'h00)
        begin
            emit_status = ST_NULL;
        end
        else if (emit_byte < CTRL_LIMIT || emit_byte == DEL_CHAR)
        begin
            emit_status = ST_CONTROL;
        end
        else if (full)
        begin
            emit_status = ST_TOO_LONG;
        end
        else
        begin
            emit_fail = 1'b0;
        end
    end

    always_comb
    begin
        logic    do_fail;
        logic    do_emit;
        status_t fail_status;

        do_fail     = 1'b0;
        do_emit     = 1'b0;
        fail_status = ST_MALFORMED;
        state_next  = state;
        count_next  = count;
        result      = '0;

        if (state.failed)
        begin
            // drop to the end of the path
            if (in_last)
            begin
                state_next = CLEAR_STATE;
                count_next = '0;
            end
        end
        else if (cap == '0 && state.phase == PH_NORMAL && count == '0)
        begin
            do_fail     = 1'b1;
            fail_status = ST_TOO_LONG;
        end
        else
        begin
            case (state.phase)
                PH_NORMAL:
                begin
                    if (in_byte == PCT_CHAR)
                    begin
                        if (in_last)
                        begin
                            do_fail = 1'b1;
                        end
                        else
                        begin
                            state_next.phase = PH_HIGH;
                        end
                    end
                    else
                    begin
                        do_emit = 1'b1;
                    end
                end
                PH_HIGH:
                begin
                    if (nib_bad || in_last)
                    begin
                        do_fail = 1'b1;
                    end
                    else
                    begin
                        state_next.high_digit = nib[3:0];
                        state_next.phase      = PH_LOW;
                    end
                end
                default:
                begin
                    // second hex digit
                    if (nib_bad)
                    begin
                        do_fail = 1'b1;
                    end
                    else
                    begin
                        do_emit = 1'b1;
                    end
                end
            endcase

            if (do_emit && emit_fail)
            begin
                do_fail     = 1'b1;
                fail_status = emit_status;
            end
        end

        if (do_fail)
        begin
            result.has_result = 1'b1;
            result.status     = fail_status;
            result.out_end    = 1'b1;
            state_next        = CLEAR_STATE;
            state_next.failed = !in_last;
            count_next        = '0;
        end
        else if (do_emit)
        begin
            result.has_result     = 1'b1;
            result.out_byte       = emit_byte;
            result.out_byte_valid = 1'b1;
            result.status         = ST_OK;
            result.out_end        = in_last;
            state_next            = CLEAR_STATE;
            count_next            = in_last ? '0 : count + 1'b1;
        end
    end

endmodule

// ----- rtl/percent_decode_validator_top.sv -----
`timescale 1ns / 1ps

// Channel      Role   Beat payload                                  Notes
// byte_stream  sink   in_byte[7:0], in_last                         one raw path byte
// result       source out_byte[7:0], out_byte_valid, status[2:0],   zero or one per byte
//                     out_end
// cfg          sink   out_capacity[11:0]                            always ready
//
// One byte per cycle sustained while result is not stalled. A byte is held in the input
// register and decoded by pdv_step while it sits there; its result is registered in the
// output register when the held byte advances, and the single state update in pdv_step
// sets the rate. Reset clears the decoder state and restores the capacity to 2048. A
// stall on result backs up through both registers to byte_stream.ready with no loss;
// bytes that make no result free their slot at once.

module percent_decode_validator_top
    import pdv_pkg::*;
#(
    parameter int CAPACITY_LIMIT = 2048
)
(
    input  logic      clk,
    input  logic      rst_n,
    pdv_in_if.sink    byte_stream,
    pdv_out_if.source result,
    pdv_cfg_if.sink   cfg
);

    // The capacity register cannot exceed 4095, so the clamp never bites above that.
    localparam int CAP_MAX = (CAPACITY_LIMIT < 4095) ? CAPACITY_LIMIT : 4095;
    localparam int CNT_W   = $clog2(CAP_MAX);
    localparam logic [CFG_W-1:0] CAP_CLAMP = CFG_W'(CAP_MAX);

    logic [CFG_W-1:0] cap_reg;
    logic [CFG_W-1:0] cap_eff;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // decoder state
    path_state_t      state_reg;
    path_state_t      state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // output register
    result_t step_result;
    logic    out_valid_reg;
    result_t out_reg;

    logic advance;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg.valid)
        begin
            cap_reg <= cfg.out_capacity;
        end
    end

    assign cap_eff = (cap_reg > CAP_CLAMP) ? CAP_CLAMP : cap_reg;

    // The held byte moves on whenever the output register is empty or being drained.
    assign advance           = !out_valid_reg || result.ready;
    assign byte_stream.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_stream.ready)
        begin
            in_valid_reg <= byte_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.valid && byte_stream.ready)
        begin
            in_byte_reg <= byte_stream.in_byte;
            in_last_reg <= byte_stream.in_last;
        end
    end

    pdv_step #(
        .CNT_W (CNT_W)
    ) u_step (
        .state      (state_reg),
        .count      (count_reg),
        .in_byte    (in_byte_reg),
        .in_last    (in_last_reg),
        .cap        (cap_eff),
        .state_next (state_next),
        .count_next (count_next),
        .result     (step_result)
    );

    // Commit the state only when the held byte actually advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{phase: PH_NORMAL, high_digit: 4'd0, failed: 1'b0};
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && step_result.has_result;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_reg <= step_result;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.out_byte       = out_reg.out_byte;
    assign result.out_byte_valid = out_reg.out_byte_valid;
    assign result.status         = out_reg.status;
    assign result.out_end        = out_reg.out_end;

endmodule
